### hdl/voltage_channel_sweep_sequencer_core_macros.svh
// assertion macros for the voltage channel sweep sequencer
// used by voltage_channel_sweep_sequencer_core, no other dependencies
`ifndef VOLTAGE_CHANNEL_SWEEP_SEQUENCER_CORE_MACROS_SVH
`define VOLTAGE_CHANNEL_SWEEP_SEQUENCER_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define VCSS_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define VCSS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/vcss_pkg.sv
// shared types and constants for the voltage channel sweep sequencer
// no dependencies
`default_nettype none

package vcss_pkg;

    localparam int unsigned TICK_HZ_DEFAULT = 1000;
    localparam int unsigned MS_PER_S        = 1000;
    localparam int unsigned SEC_PER_MIN     = 60;
    localparam int unsigned SEC_PER_HOUR    = 3600;

    localparam int unsigned NOW_W       = 32;
    localparam int unsigned CUR_W       = 24;
    localparam int unsigned CHAN_W      = 4;
    localparam int unsigned RANGE_W     = 14;
    localparam int unsigned STEADY_W    = 15;
    localparam int unsigned DUR_W       = 16;
    localparam int unsigned LEVEL_W     = 16;
    localparam int unsigned HOLD_W      = 38;
    localparam int unsigned END_W       = 40;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEADY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DURATION = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_UNIT     = 3'd5;

    // duration unit codes
    localparam logic [1:0] UNIT_SEC      = 2'd0;
    localparam logic [1:0] UNIT_MIN      = 2'd1;
    localparam logic [1:0] UNIT_HOUR     = 2'd2;
    localparam logic [1:0] UNIT_RESERVED = 2'd3;

    typedef enum logic [1:0] {
        KIND_OFF    = 2'd0,
        KIND_SWEEP  = 2'd1,
        KIND_STEADY = 2'd2,
        KIND_STEP   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        MODE_OFF    = 2'd0,
        MODE_SWEEP  = 2'd1,
        MODE_STEADY = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        PH_RISE   = 2'd0,
        PH_FALL   = 2'd1,
        PH_RETURN = 2'd2
    } phase_t;

    // load strobes for the two stages of the time conversion
    typedef struct packed {
        logic st1_load;
        logic st2_load;
    } conv_ctrl_t;

    // one result item apart from the converted time
    typedef struct packed {
        logic                record_valid;
        logic [CHAN_W-1:0]   record_channel;
        mode_t               record_mode;
        logic [LEVEL_W-1:0]  record_level_mv;
        logic [CUR_W-1:0]    record_current;
        logic                drive_write;
        logic [LEVEL_W-1:0]  drive_level_mv;
        logic                done_flag;
    } result_t;

endpackage

`default_nettype wire

### hdl/vcss_ms_conv.sv
// tick count to millisecond conversion, two pipeline stages
// depends on vcss_pkg
`default_nettype none

module vcss_ms_conv #(
    parameter int unsigned TICK_HZ = vcss_pkg::TICK_HZ_DEFAULT
) (
    input  wire logic                        aclk,
    input  wire vcss_pkg::conv_ctrl_t        ctrl,
    input  wire logic [vcss_pkg::NOW_W-1:0]  now_ticks,
    output logic      [vcss_pkg::NOW_W-1:0]  time_ms
);

    localparam int unsigned NOW_W = vcss_pkg::NOW_W;
    localparam int unsigned LO_W  = NOW_W / 2;
    localparam int unsigned HI_W  = NOW_W - LO_W;
    localparam longint unsigned LO_MAX   = (64'd1 << LO_W) - 64'd1;
    localparam longint unsigned HI_MAX   = (64'd1 << HI_W) - 64'd1;
    localparam longint unsigned MS_K     = vcss_pkg::MS_PER_S;
    // now*1000 = hi*HI_SCALE + lo*1000, HI_SCALE = QC*TICK_HZ + RC
    localparam longint unsigned HI_SCALE = MS_K << LO_W;
    localparam longint unsigned QC       = HI_SCALE / TICK_HZ;
    localparam longint unsigned RC       = HI_SCALE % TICK_HZ;
    localparam longint unsigned Y_MAX    = HI_MAX * RC + LO_MAX * MS_K;
    localparam int unsigned Y_W   = $clog2(Y_MAX + 64'd1);
    localparam int unsigned L_W   = $clog2(TICK_HZ);
    localparam int unsigned SH    = Y_W + L_W;
    // rounded-up reciprocal, exact floor for every y below 2^Y_W
    localparam longint unsigned RECIP = ((64'd1 << SH) + TICK_HZ - 64'd1) / TICK_HZ;
    localparam int unsigned M_W   = Y_W + 2;
    localparam int unsigned P_W   = Y_W + M_W;
    localparam int unsigned QC_W  = $clog2(QC + 64'd1);
    localparam int unsigned RC_W  = $clog2(TICK_HZ);
    localparam int unsigned MS_W  = $clog2(MS_K + 64'd1);

    localparam logic [QC_W-1:0] QC_C    = QC_W'(QC);
    localparam logic [RC_W-1:0] RC_C    = RC_W'(RC);
    localparam logic [MS_W-1:0] MS_C    = MS_W'(MS_K);
    localparam logic [M_W-1:0]  RECIP_C = M_W'(RECIP);

    logic [HI_W-1:0]        hi;
    logic [LO_W-1:0]        lo;
    logic [HI_W+QC_W-1:0]   hq_full;
    logic [HI_W+RC_W-1:0]   hr_full;
    logic [LO_W+MS_W-1:0]   lm_full;

    logic [NOW_W-1:0]       hq_reg;
    logic [Y_W-1:0]         hr_reg;
    logic [Y_W-1:0]         lm_reg;

    logic [Y_W-1:0]         y_sum;
    logic [P_W-1:0]         p_full;
    logic [NOW_W-1:0]       hq2_reg;
    logic [NOW_W-1:0]       q_reg;

    assign hi      = now_ticks[NOW_W-1:LO_W];
    assign lo      = now_ticks[LO_W-1:0];
    assign hq_full = hi * QC_C;
    assign hr_full = hi * RC_C;
    assign lm_full = lo * MS_C;

    // stage one: partial products of the split tick count
    always_ff @(posedge aclk) begin
        if (ctrl.st1_load) begin
            hq_reg <= NOW_W'(hq_full);
            hr_reg <= Y_W'(hr_full);
            lm_reg <= Y_W'(lm_full);
        end
    end

    assign y_sum  = hr_reg + lm_reg;
    assign p_full = y_sum * RECIP_C;

    // stage two: remainder part divided by reciprocal multiply
    always_ff @(posedge aclk) begin
        if (ctrl.st2_load) begin
            hq2_reg <= hq_reg;
            q_reg   <= NOW_W'(p_full >> SH);
        end
    end

    assign time_ms = hq2_reg + q_reg;

endmodule

`default_nettype wire

### hdl/voltage_channel_sweep_sequencer_core.sv
// top level of the voltage channel sweep sequencer
// depends on vcss_pkg, vcss_ms_conv and voltage_channel_sweep_sequencer_core_macros.svh
`default_nettype none

// One output channel sequencer. Each input item carries a command in s_tuser (off, start
// sweep, start steady, run step) with the current sample and tick count in s_tdata, and gives
// exactly one result item. The sequencer state is updated in the cycle the item is accepted;
// the tick to millisecond conversion then runs in a two stage pipeline, and the item passes
// stage one, stage two and the output register before m_tvalid rises. One item is accepted
// every cycle; s_tready only drops when all three stages hold items and the output is
// stalled by m_tready. The rate is set by the state update at acceptance, and the latency
// by the two multiply stages of the time conversion and the output register. Configuration
// writes are taken in any cycle (cfg_ready is always high) and must only be issued while
// the block holds no items.

`include "voltage_channel_sweep_sequencer_core_macros.svh"

module voltage_channel_sweep_sequencer_core #(
    parameter int unsigned TICK_HZ = vcss_pkg::TICK_HZ_DEFAULT
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,

    // input items
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [55:0]  s_tdata,   // current_sample[23:0], now_ticks[55:24]
    input  wire logic [1:0]   s_tuser,   // kind[1:0]

    // result items
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [95:0]       m_tdata,   // record_channel[3:0], record_mode[5:4],
                                         // record_level_mv[21:6], record_current[45:22],
                                         // record_time_ms[77:46], drive_level_mv[93:78],
                                         // done_flag[94], zero fill[95]
    output logic [1:0]        m_tuser,   // record_valid[0], drive_write[1]

    // configuration writes
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [vcss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [vcss_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int unsigned NOW_W    = vcss_pkg::NOW_W;
    localparam int unsigned CUR_W    = vcss_pkg::CUR_W;
    localparam int unsigned CHAN_W   = vcss_pkg::CHAN_W;
    localparam int unsigned RANGE_W  = vcss_pkg::RANGE_W;
    localparam int unsigned STEADY_W = vcss_pkg::STEADY_W;
    localparam int unsigned DUR_W    = vcss_pkg::DUR_W;
    localparam int unsigned LEVEL_W  = vcss_pkg::LEVEL_W;
    localparam int unsigned HOLD_W   = vcss_pkg::HOLD_W;
    localparam int unsigned END_W    = vcss_pkg::END_W;

    // hold ticks per unit: factor_ms * TICK_HZ / 1000 reduces to these exactly
    localparam longint unsigned FAC_SEC  = TICK_HZ;
    localparam longint unsigned FAC_MIN  = longint'(vcss_pkg::SEC_PER_MIN) * TICK_HZ;
    localparam longint unsigned FAC_HOUR = longint'(vcss_pkg::SEC_PER_HOUR) * TICK_HZ;
    localparam int unsigned FAC_W   = $clog2(FAC_HOUR + 64'd1);
    localparam int unsigned PROD_W  = DUR_W + FAC_W;
    localparam int unsigned CMP_W   = (PROD_W > HOLD_W) ? PROD_W : HOLD_W + 1;
    localparam logic [HOLD_W-1:0] HOLD_MAX = {HOLD_W{1'b1}};

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [CHAN_W-1:0]    channel_reg;
    logic [RANGE_W-1:0]   sweep_range_reg;
    logic [RANGE_W-1:0]   sweep_step_reg;
    logic [STEADY_W-1:0]  steady_level_reg;
    logic [DUR_W-1:0]     steady_duration_reg;
    logic [1:0]           duration_unit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_reg         <= '0;
            sweep_range_reg     <= '0;
            sweep_step_reg      <= RANGE_W'(1);
            steady_level_reg    <= '0;
            steady_duration_reg <= '0;
            duration_unit_reg   <= vcss_pkg::UNIT_SEC;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                vcss_pkg::REG_CHANNEL:  channel_reg         <= cfg_data[CHAN_W-1:0];
                vcss_pkg::REG_RANGE:    sweep_range_reg     <= cfg_data[RANGE_W-1:0];
                vcss_pkg::REG_STEP:     sweep_step_reg      <= cfg_data[RANGE_W-1:0];
                vcss_pkg::REG_STEADY:   steady_level_reg    <= cfg_data[STEADY_W-1:0];
                vcss_pkg::REG_DURATION: steady_duration_reg <= cfg_data[DUR_W-1:0];
                vcss_pkg::REG_UNIT:     duration_unit_reg   <= cfg_data[1:0];
                default: begin
                    // writes beyond the register list are dropped
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline handshake: stage one, stage two, output register
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, vo_reg;
    logic ready1, ready2, ready_o;
    logic accept;
    vcss_pkg::conv_ctrl_t conv_ctrl;

    assign ready_o  = !vo_reg || m_tready;
    assign ready2   = !v2_reg || ready_o;
    assign ready1   = !v1_reg || ready2;
    assign s_tready = ready1;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = vo_reg;

    assign conv_ctrl.st1_load = accept;
    assign conv_ctrl.st2_load = v1_reg && ready2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (ready1) begin
                v1_reg <= accept;
            end
            if (ready2) begin
                v2_reg <= v1_reg;
            end
            if (ready_o) begin
                vo_reg <= v2_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // input fields
    // ------------------------------------------------------------------
    vcss_pkg::kind_t      kind;
    logic [CUR_W-1:0]     cur_sample;
    logic [NOW_W-1:0]     now_ticks;

    assign kind       = vcss_pkg::kind_t'(s_tuser);
    assign cur_sample = s_tdata[CUR_W-1:0];
    assign now_ticks  = s_tdata[CUR_W+NOW_W-1:CUR_W];

    // ------------------------------------------------------------------
    // sequencer state
    // ------------------------------------------------------------------
    vcss_pkg::mode_t      run_mode_reg, run_mode_next;
    vcss_pkg::phase_t     sweep_phase_reg, sweep_phase_next;
    logic [LEVEL_W-1:0]   sweep_level_reg, sweep_level_next;
    logic                 steady_started_reg, steady_started_next;
    logic [HOLD_W-1:0]    hold_ticks_reg, hold_ticks_next;
    logic [END_W-1:0]     end_tick_reg, end_tick_next;
    logic                 finished_reg, finished_next;
    vcss_pkg::result_t    step_res;

    // sweep arithmetic in 17 signed bits, levels never leave 16 bits
    logic signed [LEVEL_W:0] lvl_s, range_s, step_s, neg_range_s, rise_sum, fall_diff;

    assign lvl_s       = {sweep_level_reg[LEVEL_W-1], sweep_level_reg};
    assign range_s     = {{(LEVEL_W+1-RANGE_W){1'b0}}, sweep_range_reg};
    assign step_s      = {{(LEVEL_W+1-RANGE_W){1'b0}}, sweep_step_reg};
    assign neg_range_s = -range_s;
    assign rise_sum    = lvl_s + step_s;
    assign fall_diff   = lvl_s - step_s;

    // steady level sign extended to the drive width
    logic [LEVEL_W-1:0] steady_lvl;
    assign steady_lvl = {{(LEVEL_W-STEADY_W){steady_level_reg[STEADY_W-1]}}, steady_level_reg};

    // hold time in ticks, saturated
    logic [FAC_W-1:0]   hold_fac;
    logic [PROD_W-1:0]  hold_prod;
    logic [CMP_W-1:0]   hold_prod_ext;
    logic [HOLD_W-1:0]  hold_sat;

    always_comb begin
        unique case (duration_unit_reg)
            vcss_pkg::UNIT_MIN:  hold_fac = FAC_W'(FAC_MIN);
            vcss_pkg::UNIT_HOUR: hold_fac = FAC_W'(FAC_HOUR);
            default:             hold_fac = FAC_W'(FAC_SEC);
        endcase
    end

    assign hold_prod     = steady_duration_reg * hold_fac;
    assign hold_prod_ext = CMP_W'(hold_prod);
    assign hold_sat      = (hold_prod_ext > CMP_W'(HOLD_MAX)) ? HOLD_MAX
                                                              : HOLD_W'(hold_prod_ext);

    // end tick: set on the first steady step, compared against on the same step
    logic [END_W-1:0] now_ext, start_end, end_cmp;
    assign now_ext   = END_W'(now_ticks);
    assign start_end = now_ext + END_W'(hold_ticks_reg);

    always_comb begin
        run_mode_next       = run_mode_reg;
        sweep_phase_next    = sweep_phase_reg;
        sweep_level_next    = sweep_level_reg;
        steady_started_next = steady_started_reg;
        hold_ticks_next     = hold_ticks_reg;
        end_tick_next       = end_tick_reg;
        finished_next       = finished_reg;
        end_cmp             = end_tick_reg;
        step_res            = '0;

        unique case (kind)
            vcss_pkg::KIND_OFF: begin
                // off while off does nothing
                if (run_mode_reg != vcss_pkg::MODE_OFF) begin
                    step_res.drive_write = 1'b1;
                    finished_next        = 1'b1;
                    run_mode_next        = vcss_pkg::MODE_OFF;
                end
            end
            vcss_pkg::KIND_SWEEP: begin
                run_mode_next    = vcss_pkg::MODE_SWEEP;
                sweep_phase_next = vcss_pkg::PH_RISE;
                sweep_level_next = '0;
                finished_next    = 1'b0;
            end
            vcss_pkg::KIND_STEADY: begin
                run_mode_next = vcss_pkg::MODE_STEADY;
                // reserved unit code keeps the previous hold time
                if (duration_unit_reg != vcss_pkg::UNIT_RESERVED) begin
                    hold_ticks_next = hold_sat;
                end
                steady_started_next = 1'b0;
                finished_next       = 1'b0;
            end
            vcss_pkg::KIND_STEP: begin
                unique case (run_mode_reg)
                    vcss_pkg::MODE_SWEEP: begin
                        step_res.record_valid    = 1'b1;
                        step_res.record_channel  = channel_reg;
                        step_res.record_mode     = vcss_pkg::MODE_SWEEP;
                        step_res.record_level_mv = sweep_level_reg;
                        step_res.record_current  = cur_sample;
                        step_res.drive_write     = 1'b1;
                        step_res.drive_level_mv  = sweep_level_reg;
                        unique case (sweep_phase_reg)
                            vcss_pkg::PH_RISE: begin
                                if (lvl_s < range_s) begin
                                    sweep_level_next = rise_sum[LEVEL_W-1:0];
                                end else begin
                                    sweep_phase_next = vcss_pkg::PH_FALL;
                                end
                            end
                            vcss_pkg::PH_FALL: begin
                                if (lvl_s > neg_range_s) begin
                                    sweep_level_next = fall_diff[LEVEL_W-1:0];
                                end else begin
                                    sweep_phase_next = vcss_pkg::PH_RETURN;
                                end
                            end
                            default: begin
                                // return to zero, then stop
                                if (lvl_s < 0) begin
                                    sweep_level_next = rise_sum[LEVEL_W-1:0];
                                end else begin
                                    step_res.drive_level_mv = '0;
                                    finished_next           = 1'b1;
                                    run_mode_next           = vcss_pkg::MODE_OFF;
                                end
                            end
                        endcase
                    end
                    vcss_pkg::MODE_STEADY: begin
                        if (!steady_started_reg) begin
                            steady_started_next     = 1'b1;
                            step_res.drive_write    = 1'b1;
                            step_res.drive_level_mv = steady_lvl;
                            end_tick_next           = start_end;
                            end_cmp                 = start_end;
                        end
                        step_res.record_valid    = 1'b1;
                        step_res.record_channel  = channel_reg;
                        step_res.record_mode     = vcss_pkg::MODE_STEADY;
                        step_res.record_level_mv = steady_lvl;
                        step_res.record_current  = cur_sample;
                        // record first, then drive zero once past the end tick
                        if (now_ext > end_cmp) begin
                            step_res.drive_write    = 1'b1;
                            step_res.drive_level_mv = '0;
                            finished_next           = 1'b1;
                            run_mode_next           = vcss_pkg::MODE_OFF;
                        end
                    end
                    default: begin
                        // run step while off gives an empty record
                    end
                endcase
            end
            default: begin
            end
        endcase

        step_res.done_flag = finished_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_mode_reg       <= vcss_pkg::MODE_OFF;
            sweep_phase_reg    <= vcss_pkg::PH_RISE;
            sweep_level_reg    <= '0;
            steady_started_reg <= 1'b0;
            hold_ticks_reg     <= '0;
            end_tick_reg       <= '0;
            finished_reg       <= 1'b0;
        end else if (accept) begin
            run_mode_reg       <= run_mode_next;
            sweep_phase_reg    <= sweep_phase_next;
            sweep_level_reg    <= sweep_level_next;
            steady_started_reg <= steady_started_next;
            hold_ticks_reg     <= hold_ticks_next;
            end_tick_reg       <= end_tick_next;
            finished_reg       <= finished_next;
        end
    end

    // ------------------------------------------------------------------
    // result pipeline, time conversion runs alongside
    // ------------------------------------------------------------------
    vcss_pkg::result_t  st1_res_reg, st2_res_reg, out_res_reg;
    logic [NOW_W-1:0]   time_ms;
    logic [NOW_W-1:0]   out_time_reg;

    vcss_ms_conv #(
        .TICK_HZ (TICK_HZ)
    ) u_ms_conv (
        .aclk      (aclk),
        .ctrl      (conv_ctrl),
        .now_ticks (now_ticks),
        .time_ms   (time_ms)
    );

    always_ff @(posedge aclk) begin
        if (conv_ctrl.st1_load) begin
            st1_res_reg <= step_res;
        end
        if (conv_ctrl.st2_load) begin
            st2_res_reg <= st1_res_reg;
        end
        if (v2_reg && ready_o) begin
            out_res_reg  <= st2_res_reg;
            // time is only reported with a record
            out_time_reg <= st2_res_reg.record_valid ? time_ms : '0;
        end
    end

    assign m_tdata = {1'b0,
                      out_res_reg.done_flag,
                      out_res_reg.drive_level_mv,
                      out_time_reg,
                      out_res_reg.record_current,
                      out_res_reg.record_level_mv,
                      out_res_reg.record_mode,
                      out_res_reg.record_channel};
    assign m_tuser = {out_res_reg.drive_write, out_res_reg.record_valid};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `VCSS_ASSERT_SAME(a_stall_only_when_full, aclk, aresetn,
        !s_tready, v1_reg && v2_reg && vo_reg && !m_tready,
        "input stalled while a pipeline stage is free")

    `VCSS_ASSERT_NEXT(a_sweep_start, aclk, aresetn,
        accept && (kind == vcss_pkg::KIND_SWEEP),
        (run_mode_reg == vcss_pkg::MODE_SWEEP) && !finished_reg && (sweep_level_reg == '0),
        "sweep start did not arm the sweep")

    `VCSS_ASSERT_SAME(a_record_has_mode, aclk, aresetn,
        vo_reg && out_res_reg.record_valid,
        out_res_reg.record_mode != vcss_pkg::MODE_OFF,
        "record delivered with mode off")

    `VCSS_ASSERT_SAME(a_no_write_zero_level, aclk, aresetn,
        vo_reg && !out_res_reg.drive_write,
        out_res_reg.drive_level_mv == '0,
        "drive level set without a drive write")

endmodule

`default_nettype wire
